// File: sv/spk_pkg.sv
package spk_pkg;

   // field widths of the stream words
   localparam int LEVEL_W    = 20;
   localparam int RANK_W     = 4;
   localparam int PCOL_W     = 11;
   localparam int NM_W       = 18;
   localparam int OFFSET_W   = 17;
   localparam int GAIN_W     = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   // calibration arithmetic
   localparam int FRAC_W    = 24;
   localparam int LIN_SHIFT = 8;
   localparam int NM_MAX    = 131071;
   localparam int NM_MIN    = -131072;

   localparam int EMIT_MAX    = 10;
   localparam int QUEUE_DEPTH = 4;

   localparam int DEF_TOP_K       = 10;
   localparam int DEF_MAX_COLUMNS = 2048;

   // register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_NM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SQUARE_GAIN = 2'd2;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd0;
   localparam logic [GAIN_W-1:0]   LINEAR_RESET = 32'h0001_0000;
   localparam logic [GAIN_W-1:0]   SQUARE_RESET = 32'd0;

   // kind of a word in the candidate queue
   localparam int OP_W = 2;
   typedef enum logic [OP_W-1:0] {
      OP_CAND     = 2'd0,
      OP_CAND_END = 2'd1,
      OP_END      = 2'd2
   } spk_op_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] offset_nm;
      logic signed [GAIN_W-1:0]   linear_gain;
      logic signed [GAIN_W-1:0]   square_gain;
   } spk_cal_type;

   typedef struct packed {
      logic [RANK_W-1:0]      rank;
      logic [PCOL_W-1:0]      peak_column;
      logic [LEVEL_W-1:0]     peak_level;
      logic signed [NM_W-1:0] wavelength_nm;
      logic                   end_of_list;
   } spk_rsp_type;

endpackage

// File: sv/spk_queue.sv
module spk_queue #(
   parameter int WORD_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [WORD_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [WORD_W-1:0] pop_data,
   output logic              empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WORD_W-1:0] words_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = words_ff[rd_ptr_ff];
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         words_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/spk_front.sv
module spk_front #(
   parameter int MAX_COLUMNS = spk_pkg::DEF_MAX_COLUMNS,
   parameter int COL_W       = $clog2(MAX_COLUMNS),
   parameter int WORD_W      = spk_pkg::OP_W + spk_pkg::LEVEL_W + COL_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [spk_pkg::LEVEL_W-1:0] column_sum,
   input  logic                        final_column,
   output logic                        push_valid,
   output logic [WORD_W-1:0]           push_data,
   input  logic                        q_full
);
   import spk_pkg::*;

   logic [LEVEL_W-1:0] prev_ff, prev_in;
   logic [LEVEL_W-1:0] cur_ff, cur_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [COL_W-1:0]   col_ctr_ff, col_ctr_in;
   logic [1:0]         held_ff, held_in;
   logic               pend_ff, pend_in;
   logic [WORD_W-1:0]  pend_word_ff, pend_word_in;
   logic               accept, judge, last_cand;
   logic [WORD_W-1:0]  word_a, word_b;

   assign req_tready = !pend_ff && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      // held column is a peak unless a neighbor is strictly greater
      judge     = (held_ff != 2'd0) && ((held_ff == 2'd1) || (prev_ff <= cur_ff))
                  && (column_sum <= cur_ff);
      last_cand = (held_ff == 2'd0) || (cur_ff <= column_sum);
      word_a    = {OP_CAND, cur_ff, cur_col_ff};
      word_b    = {(last_cand ? OP_CAND_END : OP_END), column_sum, col_ctr_ff};

      prev_in      = prev_ff;
      cur_in       = cur_ff;
      cur_col_in   = cur_col_ff;
      col_ctr_in   = col_ctr_ff;
      held_in      = held_ff;
      pend_in      = pend_ff;
      pend_word_in = pend_word_ff;
      push_valid   = 1'b0;
      push_data    = pend_word_ff;

      if (pend_ff) begin
         push_valid = 1'b1;
         if (!q_full) begin
            pend_in = 1'b0;
         end
      end

      if (accept) begin
         if (final_column) begin
            if (judge) begin
               push_valid   = 1'b1;
               push_data    = word_a;
               pend_in      = 1'b1;
               pend_word_in = word_b;
            end else begin
               push_valid = 1'b1;
               push_data  = word_b;
            end
            prev_in    = '0;
            cur_in     = '0;
            cur_col_in = '0;
            col_ctr_in = '0;
            held_in    = 2'd0;
         end else begin
            if (judge) begin
               push_valid = 1'b1;
               push_data  = word_a;
            end
            prev_in    = cur_ff;
            cur_in     = column_sum;
            cur_col_in = col_ctr_ff;
            col_ctr_in = (col_ctr_ff == COL_W'(MAX_COLUMNS - 1)) ? '0 : col_ctr_ff + 1'b1;
            held_in    = (held_ff == 2'd2) ? 2'd2 : held_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         cur_ff     <= '0;
         cur_col_ff <= '0;
         col_ctr_ff <= '0;
         held_ff    <= 2'd0;
         pend_ff    <= 1'b0;
      end else begin
         prev_ff    <= prev_in;
         cur_ff     <= cur_in;
         cur_col_ff <= cur_col_in;
         col_ctr_ff <= col_ctr_in;
         held_ff    <= held_in;
         pend_ff    <= pend_in;
      end
      pend_word_ff <= pend_word_in;
   end

endmodule

// File: sv/spk_back.sv
module spk_back #(
   parameter int TOP_K       = spk_pkg::DEF_TOP_K,
   parameter int MAX_COLUMNS = spk_pkg::DEF_MAX_COLUMNS,
   parameter int COL_W       = $clog2(MAX_COLUMNS),
   parameter int WORD_W      = spk_pkg::OP_W + spk_pkg::LEVEL_W + COL_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spk_pkg::spk_cal_type cal,
   input  logic [WORD_W-1:0]    q_data,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output spk_pkg::spk_rsp_type rsp
);
   import spk_pkg::*;

   localparam int CNT_W  = $clog2(TOP_K + 1);
   localparam int ACC_W  = 2 * COL_W + 42;
   localparam int Q_W    = ACC_W - FRAC_W;
   localparam int PROD_W = GAIN_W + COL_W + 1;
   localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(NM_MAX);
   localparam logic signed [Q_W-1:0]   Q_MIN = Q_W'(NM_MIN);
   localparam logic signed [ACC_W-1:0] BIAS  = ACC_W'((1 << FRAC_W) - 1);

   typedef enum logic [2:0] {
      B_IDLE, B_START, B_MUL, B_LO, B_HI, B_ADD, B_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [LEVEL_W-1:0]     level_ff [TOP_K];
   logic [LEVEL_W-1:0]     level_in [TOP_K];
   logic [COL_W-1:0]       col_ff [TOP_K];
   logic [COL_W-1:0]       col_in [TOP_K];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [RANK_W-1:0]      k_ff, k_in;
   logic [RANK_W-1:0]      emit_n_ff, emit_n_in;
   logic [2*COL_W-1:0]     pp_ff, pp_in;
   logic signed [PROD_W-1:0] lin_ff, lin_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   spk_rsp_type            rsp_ff, rsp_in;

   spk_op_type             op;
   logic [LEVEL_W-1:0]     c_level;
   logic [COL_W-1:0]       c_col;
   logic                   flag [TOP_K];
   logic                   prior;
   logic signed [ACC_W-1:0] acc_b;
   logic signed [Q_W-1:0]  q;
   logic signed [NM_W-1:0] nm;
   logic                   load;

   assign op        = spk_op_type'(q_data[WORD_W-1 -: OP_W]);
   assign c_level   = q_data[COL_W +: LEVEL_W];
   assign c_col     = q_data[COL_W-1:0];
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign load      = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_ready);

   // truncate toward zero, then saturate
   always_comb begin
      acc_b = acc_ff + (acc_ff[ACC_W-1] ? BIAS : '0);
      q     = acc_b[ACC_W-1:FRAC_W];
      if (q > Q_MAX) begin
         nm = NM_W'(Q_MAX);
      end else if (q < Q_MIN) begin
         nm = NM_W'(Q_MIN);
      end else begin
         nm = NM_W'(q);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      emit_n_in    = emit_n_ff;
      pp_in        = pp_ff;
      lin_in       = lin_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      prior        = 1'b0;
      for (int i = 0; i < TOP_K; i++) begin
         level_in[i] = level_ff[i];
         col_in[i]   = col_ff[i];
         flag[i]     = (i >= int'(count_ff)) || (c_level > level_ff[i])
                       || ((c_level == level_ff[i]) && (c_col > col_ff[i]));
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               if ((op == OP_CAND) || (op == OP_CAND_END)) begin
                  // sorted insert: the first place it outranks takes it
                  for (int i = 0; i < TOP_K; i++) begin
                     if (flag[i] && !prior) begin
                        level_in[i] = c_level;
                        col_in[i]   = c_col;
                     end else if (flag[i]) begin
                        level_in[i] = level_ff[(i > 0) ? i - 1 : 0];
                        col_in[i]   = col_ff[(i > 0) ? i - 1 : 0];
                     end
                     prior = flag[i];
                  end
                  if (int'(count_ff) < TOP_K) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               if ((op == OP_END) || (op == OP_CAND_END)) begin
                  state_in = B_START;
               end
            end
         end
         B_START: begin
            emit_n_in = (int'(count_ff) < EMIT_MAX) ? RANK_W'(count_ff) : RANK_W'(EMIT_MAX);
            k_in      = '0;
            if (count_ff == '0) begin
               state_in = B_IDLE;
            end else begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            pp_in    = col_ff[0] * col_ff[0];
            lin_in   = cal.linear_gain * $signed({1'b0, col_ff[0]});
            state_in = B_LO;
         end
         B_LO: begin
            acc_in   = (ACC_W'(cal.offset_nm) <<< FRAC_W) + (ACC_W'(lin_ff) <<< LIN_SHIFT);
            prod_in  = cal.square_gain * $signed({1'b0, pp_ff[COL_W-1:0]});
            state_in = B_HI;
         end
         B_HI: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            prod_in  = cal.square_gain * $signed({1'b0, pp_ff[2*COL_W-1:COL_W]});
            state_in = B_ADD;
         end
         B_ADD: begin
            acc_in   = acc_ff + (ACC_W'(prod_ff) <<< COL_W);
            state_in = B_OUT;
         end
         B_OUT: begin
            if (load) begin
               rsp_valid_in         = 1'b1;
               rsp_in.rank          = k_ff;
               rsp_in.peak_column   = PCOL_W'(col_ff[0]);
               rsp_in.peak_level    = level_ff[0];
               rsp_in.wavelength_nm = nm;
               rsp_in.end_of_list   = (k_ff == emit_n_ff - 1'b1);
               // list moves up so the next peak sits in the head entry
               for (int i = 0; i < TOP_K - 1; i++) begin
                  level_in[i] = level_ff[i+1];
                  col_in[i]   = col_ff[i+1];
               end
               k_in = k_ff + 1'b1;
               if (k_ff == emit_n_ff - 1'b1) begin
                  count_in = '0;
                  state_in = B_IDLE;
               end else begin
                  state_in = B_MUL;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         emit_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         emit_n_ff    <= emit_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pp_ff   <= pp_in;
      lin_ff  <= lin_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
      for (int i = 0; i < TOP_K; i++) begin
         level_ff[i] <= level_in[i];
         col_ff[i]   <= col_in[i];
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= TOP_K)
      else $error("entry count above list length");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_MUL || state_ff == B_LO || state_ff == B_HI
       || state_ff == B_ADD || state_ff == B_OUT) |-> (k_ff < emit_n_ff))
      else $error("emission rank past emit count");

   a_end_starts: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (op == OP_END || op == OP_CAND_END)) |=> (state_ff == B_START))
      else $error("end of spectrum did not start emission");
`endif

endmodule

// File: sv/spectral_peak_top_k_unit.sv
// spectral peak top-k unit
// req channel: one column sum per word, tdata[19:0] = column_sum, tlast marks
//   the final column of a spectrum; columns are numbered from 0 in arrival order
// csr channel: csr_index selects offset_nm (0), linear_gain (1), square_gain (2);
//   csr_ready is always high, other indexes are dropped; write only when idle
// rsp channel: after the final column, up to ten peaks in rank order, strongest
//   first; tlast marks the last peak of the list, a spectrum with no peaks
//   gives no words
// throughput: one column per cycle; a final column that closes two candidates
//   holds req_tready low while its second word waits to be pushed; the four-word
//   candidate queue fills while peaks are emitted and then stalls the req side
// sequencer: once the end of spectrum is popped from the queue, each peak passes
//   the calibration steps MUL, LO, HI, ADD and OUT in order (four multiplies and
//   three adds per peak), and OUT loads the result register
// rsp stall: the result register holds its word; the sequencer waits in its
//   output step and the req side keeps taking columns until the queue is full
// reset: synchronous, clears spectrum state, the queue, the list count and
//   restores offset_nm = 0, linear_gain = 1.0 (Q16), square_gain = 0
module spectral_peak_top_k_unit #(
   parameter int TOP_K       = spk_pkg::DEF_TOP_K,
   parameter int MAX_COLUMNS = spk_pkg::DEF_MAX_COLUMNS
) (
   input  logic                             clock,
   input  logic                             reset,
   // column_sum [19:0], zero [23:20]
   input  logic [spk_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tlast,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rank [3:0], peak_column [14:4], peak_level [34:15], wavelength_nm [52:35],
   // zero [55:53]
   output logic [spk_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [spk_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spk_pkg::GAIN_W-1:0]       csr_data
);
   import spk_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int WORD_W = OP_W + LEVEL_W + COL_W;

   // calibration registers
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [GAIN_W-1:0]   linear_ff, linear_in;
   logic [GAIN_W-1:0]   square_ff, square_in;
   spk_cal_type         cal;

   // front to queue to back
   logic              push_valid;
   logic [WORD_W-1:0] push_data;
   logic              q_full;
   logic              q_pop;
   logic [WORD_W-1:0] q_data;
   logic              q_empty;
   spk_rsp_type       rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      offset_in = offset_ff;
      linear_in = linear_ff;
      square_in = square_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_OFFSET_NM:   offset_in = csr_data[OFFSET_W-1:0];
            REG_LINEAR_GAIN: linear_in = csr_data;
            REG_SQUARE_GAIN: square_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         linear_ff <= LINEAR_RESET;
         square_ff <= SQUARE_RESET;
      end else begin
         offset_ff <= offset_in;
         linear_ff <= linear_in;
         square_ff <= square_in;
      end
   end

   assign cal.offset_nm   = offset_ff;
   assign cal.linear_gain = linear_ff;
   assign cal.square_gain = square_ff;

   // local maximum detection, one column a cycle while the candidate queue has room and no word is pending
   spk_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .COL_W       (COL_W),
      .WORD_W      (WORD_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .column_sum   (req_tdata[LEVEL_W-1:0]),
      .final_column (req_tlast),
      .push_valid   (push_valid),
      .push_data    (push_data),
      .q_full       (q_full)
   );

   // candidate queue decouples detection from ranking and emission
   spk_queue #(
      .WORD_W (WORD_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .pop_data   (q_data),
      .empty      (q_empty)
   );

   // sorted list, calibration sequencer and result register
   spk_back #(
      .TOP_K       (TOP_K),
      .MAX_COLUMNS (MAX_COLUMNS),
      .COL_W       (COL_W),
      .WORD_W      (WORD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal),
      .q_data    (q_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack the result word, lowest field first
   assign rsp_tdata = {3'b000, rsp.wavelength_nm, rsp.peak_level, rsp.peak_column, rsp.rank};
   assign rsp_tlast = rsp.end_of_list;

endmodule
